/* rtl/core/rv32id_pkg.sv */
// Shared types and constants for the RV32I instruction decoder.
// No dependencies; every rv32id_* module and the top level import this package.
package rv32id_pkg;

   // Major opcodes, bits 6..0
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_ALUI   = 7'h13;
   localparam logic [6:0] OPC_ALU    = 7'h33;
   localparam logic [6:0] OPC_FENCE  = 7'h0f;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct3 codes
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_MEM_B  = 3'd0;
   localparam logic [2:0] F3_MEM_H  = 3'd1;
   localparam logic [2:0] F3_MEM_W  = 3'd2;
   localparam logic [2:0] F3_MEM_BU = 3'd4;
   localparam logic [2:0] F3_MEM_HU = 3'd5;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [4:0] RS2_ECALL  = 5'd0;
   localparam logic [4:0] RS2_EBREAK = 5'd1;

   // Operation codes as returned on op_kind
   localparam logic [5:0] KIND_ILLEGAL = 6'd0;
   localparam logic [5:0] KIND_LUI     = 6'd1;
   localparam logic [5:0] KIND_AUIPC   = 6'd2;
   localparam logic [5:0] KIND_JAL     = 6'd3;
   localparam logic [5:0] KIND_JALR    = 6'd4;
   localparam logic [5:0] KIND_BEQ     = 6'd5;
   localparam logic [5:0] KIND_BNE     = 6'd6;
   localparam logic [5:0] KIND_BLT     = 6'd7;
   localparam logic [5:0] KIND_BGE     = 6'd8;
   localparam logic [5:0] KIND_BLTU    = 6'd9;
   localparam logic [5:0] KIND_BGEU    = 6'd10;
   localparam logic [5:0] KIND_LB      = 6'd11;
   localparam logic [5:0] KIND_LH      = 6'd12;
   localparam logic [5:0] KIND_LW      = 6'd13;
   localparam logic [5:0] KIND_LBU     = 6'd14;
   localparam logic [5:0] KIND_LHU     = 6'd15;
   localparam logic [5:0] KIND_SB      = 6'd16;
   localparam logic [5:0] KIND_SH      = 6'd17;
   localparam logic [5:0] KIND_SW      = 6'd18;
   localparam logic [5:0] KIND_ADDI    = 6'd19;
   localparam logic [5:0] KIND_SLTI    = 6'd20;
   localparam logic [5:0] KIND_SLTIU   = 6'd21;
   localparam logic [5:0] KIND_XORI    = 6'd22;
   localparam logic [5:0] KIND_ORI     = 6'd23;
   localparam logic [5:0] KIND_ANDI    = 6'd24;
   localparam logic [5:0] KIND_SLLI    = 6'd25;
   localparam logic [5:0] KIND_SRLI    = 6'd26;
   localparam logic [5:0] KIND_SRAI    = 6'd27;
   localparam logic [5:0] KIND_ADD     = 6'd28;
   localparam logic [5:0] KIND_SUB     = 6'd29;
   localparam logic [5:0] KIND_SLL     = 6'd30;
   localparam logic [5:0] KIND_SLT     = 6'd31;
   localparam logic [5:0] KIND_SLTU    = 6'd32;
   localparam logic [5:0] KIND_XOR     = 6'd33;
   localparam logic [5:0] KIND_SRL     = 6'd34;
   localparam logic [5:0] KIND_SRA     = 6'd35;
   localparam logic [5:0] KIND_OR      = 6'd36;
   localparam logic [5:0] KIND_AND     = 6'd37;
   localparam logic [5:0] KIND_FENCE   = 6'd38;
   localparam logic [5:0] KIND_ECALL   = 6'd39;
   localparam logic [5:0] KIND_EBREAK  = 6'd40;

   // Immediate format selected by the classifier
   typedef enum logic [2:0] {
      FMT_NONE,
      FMT_I,
      FMT_S,
      FMT_B,
      FMT_J,
      FMT_U,
      FMT_SH
   } fmt_type;

   typedef struct packed {
      logic [5:0] kind;
      fmt_type    fmt;
   } dec_type;

endpackage

/* rtl/core/rv32id_classify.sv */
// Operation classifier: opcode, funct3, funct7 and rs2 to operation code and
// immediate format. Depends on rv32id_pkg.
module rv32id_classify (
   input  logic [31:0]        insn_word,
   output rv32id_pkg::dec_type dec
);
   import rv32id_pkg::*;

   logic [6:0] opc;
   logic [2:0] f3;
   logic [6:0] f7;
   logic [4:0] rs2;

   assign opc = insn_word[6:0];
   assign f3  = insn_word[14:12];
   assign f7  = insn_word[31:25];
   assign rs2 = insn_word[24:20];

   always_comb begin
      dec.kind = KIND_ILLEGAL;
      dec.fmt  = FMT_NONE;
      case (opc)
         OPC_LUI: begin
            dec.kind = KIND_LUI;
            dec.fmt  = FMT_U;
         end
         OPC_AUIPC: begin
            dec.kind = KIND_AUIPC;
            dec.fmt  = FMT_U;
         end
         OPC_JAL: begin
            dec.kind = KIND_JAL;
            dec.fmt  = FMT_J;
         end
         OPC_JALR: begin
            dec.kind = KIND_JALR;
            dec.fmt  = FMT_I;
         end
         OPC_BRANCH: begin
            dec.fmt = FMT_B;
            case (f3)
               F3_BEQ:  dec.kind = KIND_BEQ;
               F3_BNE:  dec.kind = KIND_BNE;
               F3_BLT:  dec.kind = KIND_BLT;
               F3_BGE:  dec.kind = KIND_BGE;
               F3_BLTU: dec.kind = KIND_BLTU;
               F3_BGEU: dec.kind = KIND_BGEU;
               default: dec.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_LOAD: begin
            dec.fmt = FMT_I;
            case (f3)
               F3_MEM_B:  dec.kind = KIND_LB;
               F3_MEM_H:  dec.kind = KIND_LH;
               F3_MEM_W:  dec.kind = KIND_LW;
               F3_MEM_BU: dec.kind = KIND_LBU;
               F3_MEM_HU: dec.kind = KIND_LHU;
               default:   dec.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_STORE: begin
            dec.fmt = FMT_S;
            case (f3)
               F3_MEM_B: dec.kind = KIND_SB;
               F3_MEM_H: dec.kind = KIND_SH;
               F3_MEM_W: dec.kind = KIND_SW;
               default:  dec.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_ALUI: begin
            // shifts carry a 5-bit shamt instead of a full I immediate
            dec.fmt = (f3 inside {F3_SLL, F3_SR}) ? FMT_SH : FMT_I;
            case (f3)
               F3_ADD:  dec.kind = KIND_ADDI;
               F3_SLL:  dec.kind = KIND_SLLI;
               F3_SLT:  dec.kind = KIND_SLTI;
               F3_SLTU: dec.kind = KIND_SLTIU;
               F3_XOR:  dec.kind = KIND_XORI;
               F3_SR:   dec.kind = (f7 == F7_BASE) ? KIND_SRLI :
                                   (f7 == F7_ALT)  ? KIND_SRAI : KIND_ILLEGAL;
               F3_OR:   dec.kind = KIND_ORI;
               F3_AND:  dec.kind = KIND_ANDI;
               default: dec.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_ALU: begin
            dec.fmt = FMT_NONE;
            case (f3)
               F3_ADD:  dec.kind = (f7 == F7_BASE) ? KIND_ADD :
                                   (f7 == F7_ALT)  ? KIND_SUB : KIND_ILLEGAL;
               F3_SLL:  dec.kind = KIND_SLL;
               F3_SLT:  dec.kind = KIND_SLT;
               F3_SLTU: dec.kind = KIND_SLTU;
               F3_XOR:  dec.kind = KIND_XOR;
               F3_SR:   dec.kind = (f7 == F7_BASE) ? KIND_SRL :
                                   (f7 == F7_ALT)  ? KIND_SRA : KIND_ILLEGAL;
               F3_OR:   dec.kind = KIND_OR;
               F3_AND:  dec.kind = KIND_AND;
               default: dec.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_FENCE: begin
            dec.kind = KIND_FENCE;
            dec.fmt  = FMT_I;
         end
         OPC_SYSTEM: begin
            dec.fmt = FMT_I;
            if (f7 == F7_BASE && rs2 == RS2_ECALL) begin
               dec.kind = KIND_ECALL;
            end else if (f7 == F7_BASE && rs2 == RS2_EBREAK) begin
               dec.kind = KIND_EBREAK;
            end else begin
               dec.kind = KIND_ILLEGAL;
            end
         end
         default: begin
            dec.kind = KIND_ILLEGAL;
            dec.fmt  = FMT_NONE;
         end
      endcase
   end

endmodule

/* rtl/core/rv32id_immgen.sv */
// Immediate assembly, jump/branch target add and fence field extraction.
// Depends on rv32id_pkg; takes the classifier result as a dec_type struct.
module rv32id_immgen (
   input  logic [31:0]         insn_word,
   input  logic [31:0]         pc,
   input  rv32id_pkg::dec_type dec,
   output logic signed [31:0]  immediate,
   output logic [31:0]         target_addr,
   output logic [3:0]          fence_pred,
   output logic [3:0]          fence_succ
);
   import rv32id_pkg::*;

   logic [31:0] w;
   logic [31:0] imm;
   logic        legal;
   logic        is_branch;
   logic        takes_target;

   assign w = insn_word;
   assign legal = (dec.kind != KIND_ILLEGAL);
   assign is_branch = (dec.kind >= KIND_BEQ) && (dec.kind <= KIND_BGEU);
   assign takes_target = (dec.kind == KIND_JAL) || is_branch;

   always_comb begin
      case (dec.fmt)
         FMT_I:   imm = {{20{w[31]}}, w[31:20]};
         FMT_S:   imm = {{20{w[31]}}, w[31:25], w[11:7]};
         FMT_B:   imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         FMT_J:   imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         FMT_U:   imm = {w[31:12], 12'b0};
         FMT_SH:  imm = {27'b0, w[24:20]};
         default: imm = 32'b0;
      endcase
   end

   // drop everything for illegal words
   assign immediate   = legal ? $signed(imm) : 32'sd0;
   assign target_addr = takes_target ? (pc + imm) : 32'b0;
   assign fence_pred  = (dec.kind == KIND_FENCE) ? w[27:24] : 4'b0;
   assign fence_succ  = (dec.kind == KIND_FENCE) ? w[23:20] : 4'b0;

endmodule

/* rtl/core/rv32i_instruction_decoder.sv */
// RV32I instruction decoder, top level.
// rsp_valid rises once the req transaction has passed the input register and then
// the result register.
// Throughput: one instruction per cycle, set by the single decode pass between
// the two registers. Stalls on rsp_ready back-pressure.
// Reset (synchronous, active high) clears both valid flags; payload is kept.
module rv32i_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   // instruction in
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_insn_word,
   input  logic [31:0]        req_pc,
   // decode result out
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_op_kind,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic signed [31:0] rsp_immediate,
   output logic [31:0]        rsp_target_addr,
   output logic [3:0]         rsp_fence_pred,
   output logic [3:0]         rsp_fence_succ
);
   import rv32id_pkg::*;

   // Input register stage
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_insn_ff;
   logic [31:0] s1_pc_ff;

   // Result register stage
   logic               s2_valid_ff, s2_valid_in;
   logic [5:0]         s2_kind_ff;
   logic [4:0]         s2_rd_ff;
   logic [4:0]         s2_rs1_ff;
   logic [4:0]         s2_rs2_ff;
   logic signed [31:0] s2_imm_ff;
   logic [31:0]        s2_target_ff;
   logic [3:0]         s2_pred_ff;
   logic [3:0]         s2_succ_ff;

   // Decode outputs from the combinational pass
   dec_type            dec;
   logic signed [31:0] imm_in;
   logic [31:0]        target_in;
   logic [3:0]         pred_in;
   logic [3:0]         succ_in;

   logic s2_load;   // result register takes the decoded transaction
   logic s1_load;   // input register takes a new transaction

   // The result register frees up when empty or when its transaction leaves
   // this cycle; the input register frees up when empty or when it moves on.
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !s2_valid_ff || rsp_ready;
   assign s1_load   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the incoming instruction word and pc
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_insn_ff <= req_insn_word;
         s1_pc_ff   <= req_pc;
      end
   end

   rv32id_classify u_classify (
      .insn_word (s1_insn_ff),
      .dec       (dec)
   );

   rv32id_immgen u_immgen (
      .insn_word   (s1_insn_ff),
      .pc          (s1_pc_ff),
      .dec         (dec),
      .immediate   (imm_in),
      .target_addr (target_in),
      .fence_pred  (pred_in),
      .fence_succ  (succ_in)
   );

   // Hold the decoded result until the consumer takes it
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_kind_ff   <= dec.kind;
         s2_rd_ff     <= s1_insn_ff[11:7];
         s2_rs1_ff    <= s1_insn_ff[19:15];
         s2_rs2_ff    <= s1_insn_ff[24:20];
         s2_imm_ff    <= imm_in;
         s2_target_ff <= target_in;
         s2_pred_ff   <= pred_in;
         s2_succ_ff   <= succ_in;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_op_kind     = s2_kind_ff;
   assign rsp_dest_reg    = s2_rd_ff;
   assign rsp_src1_reg    = s2_rs1_ff;
   assign rsp_src2_reg    = s2_rs2_ff;
   assign rsp_immediate   = s2_imm_ff;
   assign rsp_target_addr = s2_target_ff;
   assign rsp_fence_pred  = s2_pred_ff;
   assign rsp_fence_succ  = s2_succ_ff;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for rv32i_instruction_decoder: directed and random instruction words, with
// random gaps on both channels, checked against an in-bench RV32I decode predictor.
// Depends on rv32id_pkg and the decoder RTL only.
module testbench;
   import rv32id_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 1550;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned MAX_REPORTS    = 40;

   // funct3 holes in the branch, load and store maps, and funct7 and rs2 values that no operation uses
   localparam logic [2:0] BR_F3_HOLE  = 3'd2;
   localparam logic [2:0] LD_F3_HOLE  = 3'd3;
   localparam logic [2:0] ST_F3_HOLE  = 3'd4;
   localparam logic [6:0] F7_BAD_LOW  = 7'h01;
   localparam logic [6:0] F7_BAD_HIGH = 7'h40;
   localparam logic [6:0] F7_ALL      = 7'h7f;
   localparam logic [4:0] RS2_BAD_SYS = 5'd2;

   // One decoded instruction, field for field as the rsp channel carries it
   typedef struct packed {
      logic [5:0]  kind;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
      logic [31:0] target;
      logic [3:0]  pred;
      logic [3:0]  succ;
   } decode_type;

   // One instruction waiting to be sent, with the idle cycles to insert ahead of it
   typedef struct {
      logic [31:0] word;
      logic [31:0] pc;
      int unsigned gap;
   } insn_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_insn_word = '0;
   logic [31:0]        req_pc = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [5:0]         rsp_op_kind;
   logic [4:0]         rsp_dest_reg;
   logic [4:0]         rsp_src1_reg;
   logic [4:0]         rsp_src2_reg;
   logic signed [31:0] rsp_immediate;
   logic [31:0]        rsp_target_addr;
   logic [3:0]         rsp_fence_pred;
   logic [3:0]         rsp_fence_succ;

   insn_item_type insn_backlog[$];
   decode_type    expected_decodes[$];
   int unsigned error_count = 0;
   int unsigned sent_count = 0;
   int unsigned illegal_count = 0;
   logic [40:0] kinds_hit = '0;
   int unsigned src_quiet_left = 0;

   rv32i_instruction_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_insn_word   (req_insn_word),
      .req_pc          (req_pc),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_op_kind     (rsp_op_kind),
      .rsp_dest_reg    (rsp_dest_reg),
      .rsp_src1_reg    (rsp_src1_reg),
      .rsp_src2_reg    (rsp_src2_reg),
      .rsp_immediate   (rsp_immediate),
      .rsp_target_addr (rsp_target_addr),
      .rsp_fence_pred  (rsp_fence_pred),
      .rsp_fence_succ  (rsp_fence_succ)
   );

   always #5 clock = ~clock;

   // Decode predictor: classify by opcode, funct3 and (where it matters) funct7 and rs2,
   // then pick the immediate of the format, the jump or branch target and the fence bits.
   function automatic decode_type decode_insn(logic [31:0] w, logic [31:0] pc);
      decode_type d;
      fmt_type    fmt;
      logic [2:0] f3;
      logic [6:0] f7;
      d = '0;
      fmt = FMT_NONE;
      f3 = w[14:12];
      f7 = w[31:25];
      d.rd = w[11:7];
      d.rs1 = w[19:15];
      d.rs2 = w[24:20];
      case (w[6:0])
         OPC_LUI:   begin d.kind = KIND_LUI;   fmt = FMT_U; end
         OPC_AUIPC: begin d.kind = KIND_AUIPC; fmt = FMT_U; end
         OPC_JAL:   begin d.kind = KIND_JAL;   fmt = FMT_J; end
         // funct3 of jalr and fence is a don't-care
         OPC_JALR:  begin d.kind = KIND_JALR;  fmt = FMT_I; end
         OPC_FENCE: begin d.kind = KIND_FENCE; fmt = FMT_I; end
         OPC_BRANCH: begin
            fmt = FMT_B;
            case (f3)
               F3_BEQ:  d.kind = KIND_BEQ;
               F3_BNE:  d.kind = KIND_BNE;
               F3_BLT:  d.kind = KIND_BLT;
               F3_BGE:  d.kind = KIND_BGE;
               F3_BLTU: d.kind = KIND_BLTU;
               F3_BGEU: d.kind = KIND_BGEU;
               default: d.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_LOAD: begin
            fmt = FMT_I;
            case (f3)
               F3_MEM_B:  d.kind = KIND_LB;
               F3_MEM_H:  d.kind = KIND_LH;
               F3_MEM_W:  d.kind = KIND_LW;
               F3_MEM_BU: d.kind = KIND_LBU;
               F3_MEM_HU: d.kind = KIND_LHU;
               default:   d.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_STORE: begin
            fmt = FMT_S;
            case (f3)
               F3_MEM_B: d.kind = KIND_SB;
               F3_MEM_H: d.kind = KIND_SH;
               F3_MEM_W: d.kind = KIND_SW;
               default:  d.kind = KIND_ILLEGAL;
            endcase
         end
         OPC_ALUI: begin
            fmt = (f3 == F3_SLL || f3 == F3_SR) ? FMT_SH : FMT_I;
            case (f3)
               F3_ADD:  d.kind = KIND_ADDI;
               F3_SLL:  d.kind = KIND_SLLI;
               F3_SLT:  d.kind = KIND_SLTI;
               F3_SLTU: d.kind = KIND_SLTIU;
               F3_XOR:  d.kind = KIND_XORI;
               F3_SR:   d.kind = (f7 == F7_BASE) ? KIND_SRLI :
                                 (f7 == F7_ALT) ? KIND_SRAI : KIND_ILLEGAL;
               F3_OR:   d.kind = KIND_ORI;
               default: d.kind = KIND_ANDI;
            endcase
         end
         OPC_ALU: begin
            // only add/sub and srl/sra look at funct7
            case (f3)
               F3_ADD:  d.kind = (f7 == F7_BASE) ? KIND_ADD :
                                 (f7 == F7_ALT) ? KIND_SUB : KIND_ILLEGAL;
               F3_SLL:  d.kind = KIND_SLL;
               F3_SLT:  d.kind = KIND_SLT;
               F3_SLTU: d.kind = KIND_SLTU;
               F3_XOR:  d.kind = KIND_XOR;
               F3_SR:   d.kind = (f7 == F7_BASE) ? KIND_SRL :
                                 (f7 == F7_ALT) ? KIND_SRA : KIND_ILLEGAL;
               F3_OR:   d.kind = KIND_OR;
               default: d.kind = KIND_AND;
            endcase
         end
         OPC_SYSTEM: begin
            fmt = FMT_I;
            if (f7 == F7_BASE && d.rs2 == RS2_ECALL) begin
               d.kind = KIND_ECALL;
            end else if (f7 == F7_BASE && d.rs2 == RS2_EBREAK) begin
               d.kind = KIND_EBREAK;
            end else begin
               d.kind = KIND_ILLEGAL;
            end
         end
         default: d.kind = KIND_ILLEGAL;
      endcase

      // illegal words carry no immediate, target or fence bits
      if (d.kind != KIND_ILLEGAL) begin
         case (fmt)
            FMT_I:   d.imm = {{20{w[31]}}, w[31:20]};
            FMT_S:   d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            FMT_B:   d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_J:   d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            FMT_U:   d.imm = {w[31:12], 12'h000};
            FMT_SH:  d.imm = {27'd0, w[24:20]};
            default: d.imm = '0;
         endcase
         if (d.kind == KIND_JAL || (d.kind >= KIND_BEQ && d.kind <= KIND_BGEU)) begin
            d.target = pc + d.imm;
         end
         if (d.kind == KIND_FENCE) begin
            d.pred = w[27:24];
            d.succ = w[23:20];
         end
      end
      return d;
   endfunction

   // Build a well-formed word for one operation: fix opcode, funct3 and whatever
   // funct7/rs2 bits the operation needs; leave every other bit random.
   function automatic logic [31:0] encode_op(logic [5:0] kind);
      logic [31:0] w;
      logic [6:0]  opc;
      logic [2:0]  f3;
      w = $urandom;
      opc = OPC_ALU;
      f3 = w[14:12];
      case (kind)
         KIND_LUI:    opc = OPC_LUI;
         KIND_AUIPC:  opc = OPC_AUIPC;
         KIND_JAL:    opc = OPC_JAL;
         KIND_JALR:   opc = OPC_JALR;
         KIND_BEQ:    begin opc = OPC_BRANCH; f3 = F3_BEQ; end
         KIND_BNE:    begin opc = OPC_BRANCH; f3 = F3_BNE; end
         KIND_BLT:    begin opc = OPC_BRANCH; f3 = F3_BLT; end
         KIND_BGE:    begin opc = OPC_BRANCH; f3 = F3_BGE; end
         KIND_BLTU:   begin opc = OPC_BRANCH; f3 = F3_BLTU; end
         KIND_BGEU:   begin opc = OPC_BRANCH; f3 = F3_BGEU; end
         KIND_LB:     begin opc = OPC_LOAD; f3 = F3_MEM_B; end
         KIND_LH:     begin opc = OPC_LOAD; f3 = F3_MEM_H; end
         KIND_LW:     begin opc = OPC_LOAD; f3 = F3_MEM_W; end
         KIND_LBU:    begin opc = OPC_LOAD; f3 = F3_MEM_BU; end
         KIND_LHU:    begin opc = OPC_LOAD; f3 = F3_MEM_HU; end
         KIND_SB:     begin opc = OPC_STORE; f3 = F3_MEM_B; end
         KIND_SH:     begin opc = OPC_STORE; f3 = F3_MEM_H; end
         KIND_SW:     begin opc = OPC_STORE; f3 = F3_MEM_W; end
         KIND_ADDI:   begin opc = OPC_ALUI; f3 = F3_ADD; end
         KIND_SLTI:   begin opc = OPC_ALUI; f3 = F3_SLT; end
         KIND_SLTIU:  begin opc = OPC_ALUI; f3 = F3_SLTU; end
         KIND_XORI:   begin opc = OPC_ALUI; f3 = F3_XOR; end
         KIND_ORI:    begin opc = OPC_ALUI; f3 = F3_OR; end
         KIND_ANDI:   begin opc = OPC_ALUI; f3 = F3_AND; end
         KIND_SLLI:   begin opc = OPC_ALUI; f3 = F3_SLL; end
         KIND_SRLI:   begin opc = OPC_ALUI; f3 = F3_SR; w[31:25] = F7_BASE; end
         KIND_SRAI:   begin opc = OPC_ALUI; f3 = F3_SR; w[31:25] = F7_ALT; end
         KIND_ADD:    begin f3 = F3_ADD; w[31:25] = F7_BASE; end
         KIND_SUB:    begin f3 = F3_ADD; w[31:25] = F7_ALT; end
         KIND_SLL:    f3 = F3_SLL;
         KIND_SLT:    f3 = F3_SLT;
         KIND_SLTU:   f3 = F3_SLTU;
         KIND_XOR:    f3 = F3_XOR;
         KIND_SRL:    begin f3 = F3_SR; w[31:25] = F7_BASE; end
         KIND_SRA:    begin f3 = F3_SR; w[31:25] = F7_ALT; end
         KIND_OR:     f3 = F3_OR;
         KIND_AND:    f3 = F3_AND;
         KIND_FENCE:  opc = OPC_FENCE;
         KIND_ECALL:  begin opc = OPC_SYSTEM; w[31:25] = F7_BASE; w[24:20] = RS2_ECALL; end
         default:     begin opc = OPC_SYSTEM; w[31:25] = F7_BASE; w[24:20] = RS2_EBREAK; end
      endcase
      w[14:12] = f3;
      w[6:0] = opc;
      return w;
   endfunction

   // Half random addresses, a quarter each close to either end so targets wrap
   function automatic logic [31:0] pick_pc();
      case ($urandom_range(0, 3))
         0:       return 32'hffff_f000 | $urandom_range(0, 32'hfff);
         1:       return $urandom_range(0, 32'hfff);
         default: return $urandom;
      endcase
   endfunction

   // Queue one instruction; draw its lead-in gap, with occasional runs of no gaps
   task automatic add_item(logic [31:0] word, logic [31:0] pc);
      insn_item_type item;
      item.word = word;
      item.pc = pc;
      if (src_quiet_left > 0) begin
         src_quiet_left--;
         item.gap = 0;
      end else if ($urandom_range(0, 31) == 0) begin
         src_quiet_left = 40;
         item.gap = 0;
      end else begin
         item.gap = $urandom_range(0, 3);
      end
      insn_backlog.push_back(item);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      end
   endtask

   // Driver: present the next backlog item once its gap has passed; hold valid and
   // payload steady until the transaction completes. Predict each accepted word.
   int unsigned drv_gap_count = 0;

   always @(posedge clock) begin
      insn_item_type item;
      decode_type    d;
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            d = decode_insn(req_insn_word, req_pc);
            expected_decodes.push_back(d);
            kinds_hit[d.kind] = 1'b1;
            sent_count++;
            if (d.kind == KIND_ILLEGAL) illegal_count++;
         end
         // slot is free unless a transaction is still stalled
         if (!(req_valid && !req_ready)) begin
            if (insn_backlog.size() != 0 && drv_gap_count >= insn_backlog[0].gap) begin
               item = insn_backlog.pop_front();
               req_valid <= 1'b1;
               req_insn_word <= item.word;
               req_pc <= item.pc;
               drv_gap_count = 0;
            end else begin
               req_valid <= 1'b0;
               if (insn_backlog.size() != 0) drv_gap_count++;
            end
         end
      end
   end

   // Monitor: compare each rsp transaction with the oldest prediction, then draw
   // how long to hold ready low before the next one.
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_quiet_left = 0;

   always @(posedge clock) begin
      decode_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected result, expected none, actual op_kind %0d",
                           $time, rsp_op_kind);
               end
            end else begin
               want = expected_decodes.pop_front();
               check_field("op_kind", 32'(want.kind), 32'(rsp_op_kind));
               check_field("dest_reg", 32'(want.rd), 32'(rsp_dest_reg));
               check_field("src1_reg", 32'(want.rs1), 32'(rsp_src1_reg));
               check_field("src2_reg", 32'(want.rs2), 32'(rsp_src2_reg));
               check_field("immediate", want.imm, rsp_immediate);
               check_field("target_addr", want.target, rsp_target_addr);
               check_field("fence_pred", 32'(want.pred), 32'(rsp_fence_pred));
               check_field("fence_succ", 32'(want.succ), 32'(rsp_fence_succ));
            end
            if (rsp_quiet_left > 0) begin
               rsp_quiet_left--;
               rsp_stall_left = 0;
            end else if ($urandom_range(0, 31) == 0) begin
               rsp_quiet_left = 40;
               rsp_stall_left = 0;
            end else begin
               rsp_stall_left = $urandom_range(0, 3);
            end
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
         end
         rsp_ready <= (rsp_stall_left == 0);
      end
   end

   // Watchdog: end the run if neither channel moves for too long
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_decodes.size());
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned i;
      int unsigned roll;
      logic [4:0]  flip;
      logic [31:0] word;

      // Directed: field extremes, target wrap, funct holes and funct7/rs2 rules
      add_item(32'h0000_0000, 32'h0000_0000);                    // opcode zero
      add_item(32'hffff_ffff, 32'hffff_ffff);                    // all ones
      add_item({20'hfffff, 5'd31, OPC_LUI}, 32'h0000_0000);
      add_item({20'h80000, 5'd0, OPC_AUIPC}, 32'hffff_ffff);
      add_item({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 32'h0000_0000);
      add_item({1'b0, 10'h3ff, 1'b1, 8'hff, 5'd31, OPC_JAL}, 32'hffff_f000);
      add_item({12'h800, 5'd31, F3_AND, 5'd0, OPC_JALR}, 32'h1234_5678);
      add_item({1'b1, 6'h3f, 5'd31, 5'd31, F3_BEQ, 4'hf, 1'b1, OPC_BRANCH}, 32'h0);
      add_item({1'b0, 6'h3f, 5'd0, 5'd0, F3_BGEU, 4'hf, 1'b1, OPC_BRANCH}, 32'hffff_ffff);
      add_item({F7_ALL, 5'd31, 5'd31, BR_F3_HOLE, 5'd31, OPC_BRANCH}, 32'h0000_1000);
      add_item({12'hfff, 5'd1, LD_F3_HOLE, 5'd2, OPC_LOAD}, 32'h0000_0000);
      add_item({12'h800, 5'd31, F3_MEM_HU, 5'd31, OPC_LOAD}, 32'h0000_0000);
      add_item({F7_ALL, 5'd3, 5'd4, ST_F3_HOLE, 5'd5, OPC_STORE}, 32'h0000_0000);
      add_item({F7_ALL, 5'd31, 5'd31, F3_MEM_W, 5'd31, OPC_STORE}, 32'h0000_0000);
      add_item({F7_ALL, 5'd31, 5'd1, F3_SLL, 5'd2, OPC_ALUI}, 32'h0000_0000);
      add_item({F7_ALT, 5'd17, 5'd3, F3_SR, 5'd4, OPC_ALUI}, 32'h0000_0000);
      add_item({F7_BAD_LOW, 5'd5, 5'd6, F3_SR, 5'd7, OPC_ALUI}, 32'h0000_0000);
      add_item({F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_ALU}, 32'h0000_0000);
      add_item({F7_BAD_HIGH, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_ALU}, 32'h0000_0000);
      add_item({F7_ALL, 5'd8, 5'd9, F3_SR, 5'd10, OPC_ALU}, 32'h0000_0000);
      add_item({F7_ALL, 5'd11, 5'd12, F3_SLL, 5'd13, OPC_ALU}, 32'h0000_0000);
      add_item({4'hf, 4'hf, 4'hf, 5'd31, F3_AND, 5'd31, OPC_FENCE}, 32'h0000_0000);
      add_item({F7_BASE, RS2_ECALL, 5'd31, F3_AND, 5'd31, OPC_SYSTEM}, 32'h0000_0000);
      add_item({F7_BASE, RS2_EBREAK, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM}, 32'h0000_0000);
      add_item({F7_BASE, RS2_BAD_SYS, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM}, 32'h0000_0000);
      add_item({F7_BAD_LOW, RS2_ECALL, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM}, 32'h0000_0000);

      // Random: mostly well-formed operations, some raw noise, some single-bit damage
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            word = encode_op(6'($urandom_range(KIND_LUI, KIND_EBREAK)));
         end else if (roll < 93) begin
            word = $urandom;
         end else begin
            word = encode_op(6'($urandom_range(KIND_LUI, KIND_EBREAK)));
            flip = 5'($urandom_range(0, 31));
            word[flip] = ~word[flip];
         end
         add_item(word, pick_pc());
      end

      // Hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every transaction to go in and every result to come back
      while (insn_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Decoded %0d instruction words (%0d illegal), %0d of 41 op kinds exercised.",
               sent_count, illegal_count, $countones(kinds_hit));
      $display("Both channels ran with random gaps of 0 to 3 cycles and idle-free stretches.");
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
